>>> rtl/core/double_ended_queue_unit_assert.svh
// Assertion macros for the double-ended queue.
// Each macro checks its property on the rising edge of clk while rst_n is high.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed in the following cycle");

`endif

>>> rtl/core/deq_pkg.sv
package deq_pkg;

    localparam int ACTION_BITS    = 3;
    localparam int DATA_BITS      = 32;
    localparam int STATUS_BITS    = 2;
    localparam int OCC_BITS       = 5;
    localparam int OUT_TDATA_BITS = 40;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - DATA_BITS - OCC_BITS;

    localparam logic [ACTION_BITS-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_PEEK_FRONT = 3'd4;
    localparam logic [ACTION_BITS-1:0] ACT_PEEK_BACK  = 3'd5;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    // Result of an accepted beat while its slot read is in flight.
    typedef struct packed {
        logic                   has_data;
        logic [STATUS_BITS-1:0] status;
        logic [OCC_BITS-1:0]    occupancy;
    } pend_t;

endpackage

>>> rtl/core/deq_ram.sv
module deq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the word holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/double_ended_queue_unit.sv
// Double-ended queue held in a ring of DEPTH words in one synchronous memory.
// Each result beat moves through a pending stage, for the memory read, into the output register.
// Throughput: one beat per cycle unless m_tready holds back the output; each pop or peek reads once.
// Reset (rst_n low, asynchronous): the queue is emptied and both channels go idle.
// Memory contents are not cleared; only words inside the held range are ever read.
module double_ended_queue_unit #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input channel.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [deq_pkg::DATA_BITS-1:0]        s_tdata,  // [31:0] data_in
    input  logic [deq_pkg::ACTION_BITS-1:0]      s_tuser,  // [2:0] action
    // Result channel.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [deq_pkg::OUT_TDATA_BITS-1:0]   m_tdata,  // [31:0] data_out, [36:32] occupancy
    output logic [deq_pkg::STATUS_BITS-1:0]      m_tuser   // [1:0] status
);

    import deq_pkg::*;

    // Index and count widths follow from the ring depth. Stored words are never
    // wider than the data field, since anything above it is masked off anyway.
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int SLOT_BITS = (WORD_BITS < DATA_BITS) ? WORD_BITS : DATA_BITS;

    localparam logic [IDX_W:0]   DEPTH_WIDE = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT   = CNT_W'(DEPTH);

    // Ring position a given number of places after base, wrapped once.
    function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] offset);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= DEPTH_WIDE)
        begin
            sum = sum - DEPTH_WIDE;
        end
        return sum[IDX_W-1:0];
    endfunction

    // Queue state: front index and number of words held.
    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Stage between acceptance and the output register, covering the memory read.
    logic  pend_valid_reg, pend_valid_next;
    pend_t pend_reg, pend_next;

    // Output register, so a new beat can be taken while a result waits.
    logic                   out_valid_reg, out_valid_next;
    logic [DATA_BITS-1:0]   out_data_reg, out_data_next;
    logic [STATUS_BITS-1:0] out_status_reg, out_status_next;
    logic [OCC_BITS-1:0]    out_occ_reg, out_occ_next;

    // Memory port signals.
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [SLOT_BITS-1:0] rd_data;

    logic                   s_accept;
    logic                   pend_move;
    logic                   is_full;
    logic                   is_empty;
    logic [CNT_W-1:0]       count_less;
    logic [IDX_W-1:0]       front_dec;
    logic [IDX_W-1:0]       front_inc;
    logic [IDX_W-1:0]       back_free;
    logic [IDX_W-1:0]       back_used;
    logic [STATUS_BITS-1:0] status_now;

    // The pending result moves on whenever the output register is empty or being
    // emptied; the input side is ready whenever the pending stage will be free.
    assign pend_move = pend_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !pend_valid_reg || pend_move;
    assign s_accept  = s_tvalid && s_tready;

    assign is_full    = (count_reg == FULL_CNT);
    assign is_empty   = (count_reg == '0);
    assign count_less = count_reg - CNT_W'(1);
    assign front_dec  = (front_reg == '0) ? LAST_IDX : front_reg - IDX_W'(1);
    assign front_inc  = ring_pos(front_reg, IDX_W'(1));
    // Slot just past the back, used by push back (only when not full).
    assign back_free  = ring_pos(front_reg, count_reg[IDX_W-1:0]);
    // Slot holding the back word, used by pop and peek back (only when not empty).
    assign back_used  = ring_pos(front_reg, count_less[IDX_W-1:0]);

    // Decode the accepted action: update indices, write a pushed word, or issue
    // the read for a pop or peek. Each action touches the memory once, and state
    // changes at the accepting edge, so consecutive beats see an up-to-date ring.
    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = front_dec;
        rd_en      = 1'b0;
        rd_addr    = front_reg;
        status_now = ST_OK;

        if (s_accept)
        begin
            unique case (s_tuser)
                ACT_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_now = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = front_dec;
                        front_next = front_dec;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ACT_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_now = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = back_free;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ACT_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_now = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = front_reg;
                        front_next = front_inc;
                        count_next = count_less;
                    end
                end
                ACT_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_now = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = back_used;
                        count_next = count_less;
                    end
                end
                ACT_PEEK_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_now = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = front_reg;
                    end
                end
                ACT_PEEK_BACK:
                begin
                    if (is_empty)
                    begin
                        status_now = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = back_used;
                    end
                end
                default:
                begin
                    // Unused action codes leave everything as it is.
                    status_now = ST_OK;
                end
            endcase
        end
    end

    // Pending stage: a beat enters on acceptance and leaves when the output
    // register can take it. Both can happen at the same edge.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (pend_move)
        begin
            pend_valid_next = 1'b0;
        end
        if (s_accept)
        begin
            pend_valid_next     = 1'b1;
            pend_next.has_data  = rd_en;
            pend_next.status    = status_now;
            pend_next.occupancy = OCC_BITS'(count_next);
        end
    end

    // Output register. The read word is still in the memory's read register,
    // because no later read can be issued before this beat has moved on.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_occ_next    = out_occ_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (pend_move)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = pend_reg.has_data ? DATA_BITS'(rd_data) : '0;
            out_status_next = pend_reg.status;
            out_occ_next    = pend_reg.occupancy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg      <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            front_reg      <= front_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        pend_reg       <= pend_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_occ_reg    <= out_occ_next;
    end

    deq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (SLOT_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata[SLOT_BITS-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_BITS{1'b0}}, out_occ_reg, out_data_reg};
    assign m_tuser  = out_status_reg;

`include "double_ended_queue_unit_assert.svh"

    // The count never runs past the ring depth.
    `DEQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= FULL_CNT)
    // A push into a full ring must change neither the count nor the front.
    `DEQ_ASSERT_NEXT(a_full_push_holds,
        s_accept && is_full && (s_tuser == ACT_PUSH_FRONT || s_tuser == ACT_PUSH_BACK),
        count_reg == $past(count_reg) && front_reg == $past(front_reg))
    // An empty result carries no word and reports an empty ring.
    `DEQ_ASSERT_NOW(a_empty_result,
        m_tvalid && m_tuser == ST_EMPTY,
        out_data_reg == '0 && out_occ_reg == '0)

endmodule
